@@ hdl/ise_pkg.sv @@
// Shared types and constants for the insertion sort engine.
// No dependencies.
package ise_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_EMIT
    } ise_state_t;

    // controller -> datapath
    typedef struct packed {
        logic             insert;
        logic             shift;
        logic [CNT_W-1:0] count;
    } ise_cmd_t;

endpackage

@@ hdl/ise_ctrl.sv @@
// Controller for the insertion sort engine: handshakes, entry count, drop flag.
// Depends on ise_pkg.
module ise_ctrl
    import ise_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     last_in,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output logic     last_out,
    output logic     overflow,
    output ise_cmd_t cmd
);

    ise_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // In ST_EMIT the count doubles as the number of words still to send.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        cmd.insert   = 1'b0;
        cmd.shift    = 1'b0;
        cmd.count    = count_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.shift  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next   = ST_COLLECT;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    assign last_out = (count_reg == CNT_W'(1));
    assign overflow = dropped_reg;

endmodule

@@ hdl/ise_datapath.sv @@
// Chain of compare-and-shift cells holding the sorted set, head at cell 0.
// Depends on ise_pkg.
module ise_datapath
    import ise_pkg::*;
(
    input  logic                     clk,
    input  ise_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] value_in,
    output logic signed [DATA_W-1:0] head_value
);

    logic signed [DATA_W-1:0] cell_reg  [MAX_ITEMS];
    logic signed [DATA_W-1:0] cell_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]     gt;

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            logic take_prev;
            logic place_new;

            // valid entry strictly greater than the new value moves up
            assign gt[i] = (CNT_W'(i) < cmd.count) && (cell_reg[i] > value_in);

            if (i == 0)
            begin : g_first
                assign take_prev = 1'b0;
            end
            else
            begin : g_rest
                assign take_prev = gt[i-1];
            end

            assign place_new = !take_prev && (gt[i] || (CNT_W'(i) == cmd.count));

            always_comb
            begin
                cell_next[i] = cell_reg[i];
                if (cmd.insert)
                begin
                    if (take_prev)
                    begin
                        cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
                    end
                    else if (place_new)
                    begin
                        cell_next[i] = value_in;
                    end
                end
                else if (cmd.shift)
                begin
                    cell_next[i] = cell_reg[(i == MAX_ITEMS - 1) ? i : i + 1];
                end
            end

            always_ff @(posedge clk)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    endgenerate

    assign head_value = cell_reg[0];

endmodule

@@ hdl/insertion_sort_engine.sv @@
// Insertion sort engine: one word inserted per cycle while collecting, set emitted on last.
// The first result is valid in the cycle after the last word is taken, then one
// result per cycle while out_stall is low.
// Throughput: one input word per cycle while collecting; input stalls while the
// N results of a set are sent.
// Reset clears the count and overflow flag; cell contents are not reset.
module insertion_sort_engine
    import ise_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] value_in,
    input  logic                     last_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflow
);

    ise_cmd_t cmd;

    ise_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_in   (last_in),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .last_out  (last_out),
        .overflow  (overflow),
        .cmd       (cmd)
    );

    ise_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .value_in   (value_in),
        .head_value (sorted_value)
    );

endmodule
